### design/vafd_pkg.sv
// package for the vag adpcm frame decoder
// holds the front-to-back queue entry type, frame constants and filter coefficients
// no dependencies
package vafd_pkg;

  // byte positions within a 16-byte frame
  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_FLAGS  = 4'd1;

  // header clamping limits
  localparam logic [3:0] FILTER_MAX    = 4'd4;
  localparam logic [3:0] SHIFT_MAX     = 4'd12;
  localparam logic [3:0] SHIFT_DEFAULT = 4'd9;

  // saturation limits
  localparam logic signed [19:0] PCM_MAX = 20'sd32767;
  localparam logic signed [19:0] PCM_MIN = -20'sd32768;

  // one data byte with the frame settings that apply to it
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] filter;
    logic [3:0] shift;
    logic       clear;
  } vafd_entry_t;

  // positive-history tap
  function automatic logic signed [7:0] coef_pos(input logic [2:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // second-history tap
  function automatic logic signed [7:0] coef_neg(input logic [2:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

### design/vafd_if.sv
// channel interfaces for the vag adpcm frame decoder
// byte input channel and pcm result channel, valid/ready handshake
// no dependencies
interface vafd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       sample_start;

  modport source (output valid, output data_byte, output sample_start, input ready);
  modport sink   (input valid, input data_byte, input sample_start, output ready);
endinterface

interface vafd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               pair_last;

  modport source (output valid, output pcm_sample, output pair_last, input ready);
  modport sink   (input valid, input pcm_sample, input pair_last, output ready);
endinterface

### design/vag_adpcm_frame_decoder.sv
// top level of the vag adpcm frame decoder
// front end, entry queue and back end joined by valid/ready channels
// depends on vafd_pkg, vafd_if, vafd_front, vafd_queue, vafd_back
//
// usage:
//   in_ch takes one stream byte per transfer; sample_start marks the first
//   byte of a new sample and clears history and frame position. each
//   16-byte frame is a header byte (filter, shift), a flags byte and 14
//   data bytes. header and flags bytes give no result; each data byte gives
//   two pcm samples on out_ch, low nibble first, pair_last set on the second.
//   with the queue empty, a data byte is first written into the queue, then
//   decoded into the output register, low nibble first, then high nibble.
//   the back end decodes one nibble per cycle while an entry is queued and
//   out_ch is not stalled; the rate is set by the predictor loop, since
//   each sample feeds the next through the history registers.
//   the front end runs ahead of the back end by up to QUEUE_DEPTH data bytes.
//   reset (rst_n low, synchronous) empties the queue, drops any held result
//   and zeroes frame position, filter, shift and history.
//   a stall on out_ch holds the current sample; the queue then fills and
//   in_ch ready drops until the back end drains it.
module vag_adpcm_frame_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  vafd_in_if.sink     in_ch,
  vafd_out_if.source  out_ch
);
  import vafd_pkg::*;

  logic        push, push_ready;
  vafd_entry_t push_entry;
  logic        pop, pop_valid;
  vafd_entry_t pop_entry;

  // classify bytes and hold frame settings
  vafd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data_byte    (in_ch.data_byte),
    .in_sample_start (in_ch.sample_start),
    .push            (push),
    .push_entry      (push_entry),
    .push_ready      (push_ready)
  );

  // decouple front and back
  vafd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  // nibble decode and output register
  vafd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ent_valid      (pop_valid),
    .ent            (pop_entry),
    .pop            (pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_pcm_sample (out_ch.pcm_sample),
    .out_pair_last  (out_ch.pair_last)
  );

endmodule

### design/vafd_front.sv
// front end of the vag adpcm frame decoder
// tracks frame position, latches header settings, forwards data bytes to the queue
// depends on vafd_pkg
module vafd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_sample_start,
  output logic                  push,
  output vafd_pkg::vafd_entry_t push_entry,
  input  logic                  push_ready
);
  import vafd_pkg::*;

  logic [3:0] pos_r, pos_nxt;
  logic [2:0] filter_r, filter_nxt;
  logic [3:0] shift_r, shift_nxt;
  logic       clear_pend_r, clear_pend_nxt;

  logic       accept;
  logic [3:0] pos_cur;
  logic [3:0] hdr_filter;
  logic [3:0] hdr_shift;
  logic       is_data;

  // the queue gates every transfer, header bytes included
  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  // start flag forces the byte to frame position zero
  assign pos_cur    = in_sample_start ? POS_HEADER : pos_r;
  assign is_data    = (pos_cur != POS_HEADER) && (pos_cur != POS_FLAGS);
  assign hdr_filter = in_data_byte[7:4];
  assign hdr_shift  = in_data_byte[3:0];

  // classify the byte and update frame state
  always_comb begin
    pos_nxt        = pos_r;
    filter_nxt     = filter_r;
    shift_nxt      = shift_r;
    clear_pend_nxt = clear_pend_r;
    if (accept) begin
      pos_nxt = pos_cur + 4'd1;
      if (pos_cur == POS_HEADER) begin
        filter_nxt = (hdr_filter > FILTER_MAX) ? 3'd0 : hdr_filter[2:0];
        shift_nxt  = (hdr_shift > SHIFT_MAX) ? SHIFT_DEFAULT : hdr_shift;
      end
      if (is_data) begin
        clear_pend_nxt = 1'b0;
      end else if (in_sample_start) begin
        clear_pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      filter_r     <= '0;
      shift_r      <= '0;
      clear_pend_r <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      filter_r     <= filter_nxt;
      shift_r      <= shift_nxt;
      clear_pend_r <= clear_pend_nxt;
    end
  end

  // data bytes go to the back end with the settings of their frame
  assign push              = accept && is_data;
  assign push_entry.data   = in_data_byte;
  assign push_entry.filter = filter_r;
  assign push_entry.shift  = shift_r;
  assign push_entry.clear  = clear_pend_r || in_sample_start;

endmodule

### design/vafd_queue.sv
// short queue between the front and back ends of the vag adpcm frame decoder
// register-based fifo of queue entries
// depends on vafd_pkg
module vafd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  vafd_pkg::vafd_entry_t push_entry,
  output logic                  push_ready,
  input  logic                  pop,
  output logic                  pop_valid,
  output vafd_pkg::vafd_entry_t pop_entry
);
  import vafd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vafd_entry_t    mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue occupancy above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  a_push_notfull: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("push into full queue");

endmodule

### design/vafd_back.sv
// back end of the vag adpcm frame decoder
// decodes one nibble per cycle while not stalled, through the two-tap predictor into the output register
// depends on vafd_pkg
module vafd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ent_valid,
  input  vafd_pkg::vafd_entry_t     ent,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        out_pcm_sample,
  output logic                      out_pair_last
);
  import vafd_pkg::*;

  logic               phase_r, phase_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] sample_r;
  logic               last_r;
  logic signed [15:0] hist1_r, hist2_r;

  logic               advance;
  logic               clear_now;
  logic [3:0]         nib;
  logic signed [15:0] h1, h2;
  logic signed [15:0] step_raw, step_sh;
  logic signed [23:0] prod1, prod2;
  logic signed [24:0] acc;
  logic signed [18:0] pred;
  logic signed [19:0] sum;
  logic signed [15:0] sat;

  // a nibble moves on when the output register is free or being drained
  assign advance   = ent_valid && (!out_valid_r || out_ready);
  assign pop       = advance && phase_r;
  assign clear_now = ent.clear && !phase_r;

  // low nibble first
  assign nib = phase_r ? ent.data[7:4] : ent.data[3:0];
  assign h1  = clear_now ? 16'sd0 : hist1_r;
  assign h2  = clear_now ? 16'sd0 : hist2_r;

  // scaled code, arithmetic shift rounds toward minus infinity
  assign step_raw = {nib, 12'h000};
  assign step_sh  = step_raw >>> ent.shift;

  // two-tap prediction scaled by 1/64
  assign prod1 = 24'(h1) * 24'(coef_pos(ent.filter));
  assign prod2 = 24'(h2) * 24'(coef_neg(ent.filter));
  assign acc   = 25'(prod1) + 25'(prod2);
  assign pred  = 19'(acc >>> 6);
  assign sum   = 20'(pred) + 20'(step_sh);

  // saturate to 16 bits
  always_comb begin
    priority if (sum > PCM_MAX) begin
      sat = 16'sh7fff;
    end else if (sum < PCM_MIN) begin
      sat = 16'sh8000;
    end else begin
      sat = 16'(sum);
    end
  end

  // control state
  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      phase_nxt     = !phase_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // history and output payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist1_r <= '0;
      hist2_r <= '0;
    end else if (advance) begin
      hist1_r <= sat;
      hist2_r <= h1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_r <= sat;
      last_r   <= phase_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pcm_sample = sample_r;
  assign out_pair_last  = last_r;

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("decoded sample not registered");

  a_pop_on_high: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !phase_r)
    else $error("phase not back to low nibble after pop");

  a_low_then_high: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !phase_r) |=> phase_r)
    else $error("high nibble phase missed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !advance)
    else $error("held sample overwritten");

endmodule

### test/tb_vag_adpcm_frame_decoder.sv
// testbench for the vag adpcm frame decoder: frame streams in, checked pcm samples out
// scoreboard class predicts each sample from the byte stream, tasks drive the channels
// depends on vafd_pkg, vafd_if and vag_adpcm_frame_decoder
module tb_vag_adpcm_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import vafd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int FRAMES_PER_PHASE = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTED = 10;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic signed [15:0] pcm;
    logic               pair_last;
  } pcm_expect_t;

  // decoder model and in-order sample checker
  class vafd_decode_scoreboard;
    logic [3:0]         frame_pos;
    logic [2:0]         filt;
    logic [3:0]         shamt;
    logic signed [15:0] hist_recent;
    logic signed [15:0] hist_older;
    pcm_expect_t        pcm_expect_q[$];
    int                 taps_recent[5] = '{0, 60, 115, 98, 122};
    int                 taps_older[5]  = '{0, 0, -52, -55, -60};
    int                 mismatches;
    int                 samples_checked;
    int                 bytes_noted;
    int                 headers_clamped;

    function new();
      frame_pos       = '0;
      filt            = '0;
      shamt           = '0;
      hist_recent     = '0;
      hist_older      = '0;
      mismatches      = 0;
      samples_checked = 0;
      bytes_noted     = 0;
      headers_clamped = 0;
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTED) $display("mismatch: %s", msg);
    endfunction

    // one nibble through shift, two-tap prediction and saturation
    function logic signed [15:0] decode_code(logic [3:0] code);
      logic signed [15:0] scaled;
      int pred;
      int sum;
      scaled = $signed({code, 12'h000}) >>> shamt;
      pred = (int'(hist_recent) * taps_recent[filt] + int'(hist_older) * taps_older[filt]) >>> 6;
      sum = int'(scaled) + pred;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      hist_older  = hist_recent;
      hist_recent = sum[15:0];
      return sum[15:0];
    endfunction

    // accepted input byte: update frame state, queue any samples it yields
    function void note_byte(logic [7:0] data, logic start);
      logic [3:0]  pos;
      logic [3:0]  f_nib;
      logic [3:0]  s_nib;
      pcm_expect_t e;
      bytes_noted++;
      if (start) begin
        hist_recent = '0;
        hist_older  = '0;
        frame_pos   = '0;
      end
      pos = frame_pos;
      frame_pos = frame_pos + 4'd1;
      if (pos == POS_HEADER) begin
        f_nib = data[7:4];
        s_nib = data[3:0];
        filt  = (f_nib > FILTER_MAX) ? 3'd0 : f_nib[2:0];
        shamt = (s_nib > SHIFT_MAX) ? SHIFT_DEFAULT : s_nib;
        if (f_nib > FILTER_MAX || s_nib > SHIFT_MAX) headers_clamped++;
      end else if (pos != POS_FLAGS) begin
        e.pcm = decode_code(data[3:0]);
        e.pair_last = 1'b0;
        pcm_expect_q.push_back(e);
        e.pcm = decode_code(data[7:4]);
        e.pair_last = 1'b1;
        pcm_expect_q.push_back(e);
      end
    endfunction

    // accepted result: compare with the oldest expected sample
    function void check_sample(logic signed [15:0] pcm, logic pair_last);
      pcm_expect_t e;
      if (pcm_expect_q.size() == 0) begin
        note_mismatch($sformatf("unexpected sample pcm=%0d pair_last=%0b", pcm, pair_last));
        return;
      end
      e = pcm_expect_q.pop_front();
      samples_checked++;
      if (pcm !== e.pcm || pair_last !== e.pair_last)
        note_mismatch($sformatf("sample %0d: expected pcm=%0d pair_last=%0b, got pcm=%0d pair_last=%0b",
                                samples_checked, e.pcm, e.pair_last, pcm, pair_last));
    endfunction

    function int pending();
      return pcm_expect_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  idle_mode_t idle_mode = IDLE_NONE;
  vafd_decode_scoreboard pcm_board = new();

  vafd_in_if  in_ch();
  vafd_out_if out_ch();

  vag_adpcm_frame_decoder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // result channel ready, stalling at the rate of the current phase
  initial begin
    int stall_pct;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      case (idle_mode)
        IDLE_RECEIVER: stall_pct = 67;
        IDLE_BOTH:     stall_pct = 25;
        default:       stall_pct = 0;
      endcase
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      pcm_board.check_sample(out_ch.pcm_sample, out_ch.pair_last);
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] data, logic start);
    int idle_pct;
    idle_pct = (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 25 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= data;
    in_ch.sample_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pcm_board.note_byte(data, start);
  endtask

  // frame with random content; mostly legal headers, length may be cut short
  task automatic send_frame(logic start, int frame_len);
    logic [7:0] header;
    if ($urandom_range(0, 4) != 0)
      header = {4'($urandom_range(0, 4)), 4'($urandom_range(0, 12))};
    else
      header = 8'($urandom_range(0, 255));
    send_byte(header, start);
    for (int i = 1; i < frame_len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic run_phase(idle_mode_t mode);
    bit cut;
    bit was_cut;
    idle_mode = mode;
    was_cut = 1'b0;
    for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
      // about one frame in eight is broken off, and the next one restarts the sample
      cut = ($urandom_range(0, 7) == 0);
      send_frame(was_cut || $urandom_range(0, 3) == 0, cut ? $urandom_range(1, 15) : 16);
      was_cut = cut;
    end
    // a phase ends on a frame boundary reached through a fresh start
    if (was_cut) send_frame(1'b1, 16);
  endtask

  // directed stream: bit 8 is the start flag, bits 7:0 the byte
  logic [8:0] directed_stream[$] = '{
    9'h140, 9'h0A5, 9'h077, 9'h077, 9'h077, 9'h088, 9'h088, 9'h088, 9'h0FF, 9'h000,
    9'h0F0, 9'h00F, 9'h080, 9'h008, 9'h07F, 9'h0F7,
    // frame follows without a start; filter and shift both out of range
    9'h0FD, 9'h000, 9'h012, 9'h09E,
    // restart mid-frame: filter out of range, largest legal shift
    9'h15C, 9'h0FF, 9'h088,
    9'h13E, 9'h05A
  };

  initial begin
    bit timed_out;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.sample_start = 1'b0;
    timed_out          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fork
      begin
        idle_mode = IDLE_NONE;
        foreach (directed_stream[i]) send_byte(directed_stream[i][7:0], directed_stream[i][8]);
        run_phase(IDLE_NONE);
        run_phase(IDLE_SENDER);
        run_phase(IDLE_RECEIVER);
        run_phase(IDLE_BOTH);
        in_ch.valid <= 1'b0;
        while (pcm_board.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
          @(posedge clk);
          if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
          else
            quiet_cycles++;
        end
        timed_out = 1'b1;
      end
    join_any

    if (timed_out) $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    if (pcm_board.pending() > 0)
      pcm_board.note_mismatch($sformatf("%0d expected samples never arrived", pcm_board.pending()));
    $display("covered %0d stream bytes over four idling phases, %0d pcm samples checked",
             pcm_board.bytes_noted, pcm_board.samples_checked);
    $display("%0d headers needed clamping, %0d mismatches counted",
             pcm_board.headers_clamped, pcm_board.mismatches);
    if (!timed_out && pcm_board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
